[rtl/sstacc_pkg.sv]
// sstacc_pkg: command and status codes, bus widths and Q16.16 helpers
// for the sorted sparse term accumulator. No dependencies.

package sstacc_pkg;

	localparam int MAX_TERMS_DEF = 64;
	localparam int ID_BITS_DEF   = 16;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 96;
	localparam int TOL_W      = 31;

	localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

	typedef enum logic [2:0] {
		CMD_ADD_TERM  = 3'd0,
		CMD_SCALE     = 3'd1,
		CMD_ADD_CONST = 3'd2,
		CMD_READ      = 3'd3,
		CMD_CLEAR     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] value;
	} qres_t;

	// Saturating Q16.16 add.
	function automatic qres_t q_add(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [32:0] s;
		qres_t r;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31]) begin
			r.sat   = 1'b1;
			r.value = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r.sat   = 1'b0;
			r.value = s[31:0];
		end
		return r;
	endfunction

	// Product >> 16, round half up, then clamp.
	function automatic qres_t q_round(input logic signed [63:0] p);
		logic [63:0] u;
		logic [47:0] t;
		qres_t r;
		u = p + 64'h0000_0000_0000_8000;
		t = u[63:16];
		if ((&t[47:31]) || !(|t[47:31])) begin
			r.sat   = 1'b0;
			r.value = t[31:0];
		end else begin
			r.sat   = 1'b1;
			r.value = t[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	// Exact magnitude; the most negative value maps to 2^31.
	function automatic logic [31:0] q_mag(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

[rtl/sorted_sparse_term_accumulator_unit.sv]
// Sorted sparse term accumulator: sorted (id, coefficient) table in a
// single-port-write memory plus a constant term, run by one sequencer.
// Depends on sstacc_pkg.
//
// channel    dir  handshake                        payload
// s_axis     in   s_axis_tvalid / s_axis_tready    command, var_id, value, entry_index
// m_axis     out  m_axis_tvalid / m_axis_tready    status, entry_count, out_var_id,
//                                                  out_coeff, constant_term, saturated
// cfg        in   cfg_wen                          cancel_tolerance
//
// Work per word: add term checks the entries below the id one by one, then
// moves the entries above the position up on insert or down on erase.
// Scale reads, multiplies and writes back each live entry in turn, then the
// constant (one shared 32x32 multiplier, registered product).
// Read entry waits for the table read (not when out of range); add
// constant, clear and unknown commands go straight to the final state.
// s_axis_tready is high only while the sequencer is idle. A finished word
// waits in the output register; the next input word is taken meanwhile and
// its result waits in the final state until the output register frees up.
// Reset empties the table (count to zero) and zeroes the constant; the
// memory itself is not cleared, entries at or beyond the count are never used.

module sorted_sparse_term_accumulator_unit
	import sstacc_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF,
	parameter int ID_BITS   = ID_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [2:0] command, [18:3] var_id, [50:19] value, [56:51] entry_index
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [1:0] status, [8:2] entry_count, [24:9] out_var_id, [56:25] out_coeff,
	// [88:57] constant_term, [89] saturated
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_wen,
	input  logic [TOL_W-1:0]      cfg_wdata
);

	localparam int AW = $clog2(MAX_TERMS);
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TERMS);

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic signed [31:0] coeff;
	} term_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_NEW,
		S_INS_RD,
		S_INS_WR,
		S_ERASE_RD,
		S_ERASE_WR,
		S_SCL_RD,
		S_SCL_MUL,
		S_SCL_WR,
		S_CONST_MUL,
		S_CONST_WR,
		S_READ_WAIT,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        pos_q;
	logic [CW-1:0]        cur_q;
	logic signed [31:0]   const_q;
	logic [TOL_W-1:0]     tol_q;
	logic [ID_BITS-1:0]   id_q;
	logic signed [31:0]   val_q;
	logic signed [63:0]   prod_q;
	logic                 sat_q;
	status_t              st_q;
	logic [ID_BITS-1:0]   rid_q;
	logic signed [31:0]   rcoeff_q;
	logic                 ovalid_q;
	logic [OUT_DATA_W-1:0] tdata_q;

	term_t                mem_q [MAX_TERMS];
	term_t                rd_q;

	// input fields
	cmd_t                 in_cmd;
	logic [15:0]          in_var_id;
	logic signed [31:0]   in_value;
	logic [5:0]           in_index;
	logic [ID_BITS+15:0]  in_id_ext;
	logic [ID_BITS-1:0]   in_id;
	logic [AW+5:0]        in_idx_ext;
	logic                 idx_ok;

	logic                 accept;
	logic                 out_free;
	qres_t                add_r;
	logic [31:0]          add_mag;
	logic [31:0]          val_mag;
	qres_t                const_add;
	logic signed [31:0]   mul_a;
	logic signed [63:0]   mul_p;
	qres_t                mul_r;
	logic [CW-1:0]        cur_p1;
	logic [CW-1:0]        cur_m1;
	logic [ID_BITS+15:0]  rid_ext;
	logic [CW+6:0]        cnt_ext;

	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [AW-1:0]        mem_ra;
	term_t                mem_wd;

	assign in_cmd     = cmd_t'(s_axis_tdata[2:0]);
	assign in_var_id  = s_axis_tdata[18:3];
	assign in_value   = s_axis_tdata[50:19];
	assign in_index   = s_axis_tdata[56:51];
	assign in_id_ext  = (ID_BITS + 16)'(in_var_id);
	assign in_id      = in_id_ext[ID_BITS-1:0];
	assign in_idx_ext = (AW + 6)'(in_index);
	assign idx_ok     = (CW + 6)'(in_index) < (CW + 6)'(cnt_q);

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !ovalid_q || m_axis_tready;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = tdata_q;

	assign add_r     = q_add(rd_q.coeff, val_q);
	assign add_mag   = q_mag(add_r.value);
	assign val_mag   = q_mag(val_q);
	assign const_add = q_add(const_q, in_value);

	// shared multiplier: table coefficient during the sweep, then the constant
	assign mul_a = (state_q == S_SCL_MUL) ? rd_q.coeff : const_q;
	assign mul_p = mul_a * val_q;
	assign mul_r = q_round(prod_q);

	assign cur_p1  = cur_q + 1'b1;
	assign cur_m1  = cur_q - 1'b1;
	assign rid_ext = (ID_BITS + 16)'(rid_q);
	assign cnt_ext = (CW + 7)'(cnt_q);

	// memory port control
	always_comb begin
		mem_ra = pos_q[AW-1:0];
		mem_we = 1'b0;
		mem_wa = pos_q[AW-1:0];
		mem_wd = rd_q;
		case (state_q)
			S_IDLE: begin
				mem_ra = in_idx_ext[AW-1:0];
			end
			S_SCAN_CHK: begin
				if (rd_q.id == id_q && add_mag > 32'(tol_q)) begin
					mem_we = 1'b1;
					mem_wd = '{id: id_q, coeff: add_r.value};
				end
			end
			S_INS_RD: begin
				mem_ra = cur_m1[AW-1:0];
				if (cur_q == pos_q) begin
					mem_we = 1'b1;
					mem_wd = '{id: id_q, coeff: val_q};
				end
			end
			S_INS_WR: begin
				mem_we = 1'b1;
				mem_wa = cur_q[AW-1:0];
			end
			S_ERASE_RD: begin
				mem_ra = cur_p1[AW-1:0];
			end
			S_ERASE_WR: begin
				mem_we = 1'b1;
				mem_wa = cur_q[AW-1:0];
			end
			S_SCL_WR: begin
				mem_we = 1'b1;
				mem_wd = '{id: rd_q.id, coeff: mul_r.value};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			pos_q    <= '0;
			cur_q    <= '0;
			const_q  <= '0;
			tol_q    <= TOL_RESET;
			id_q     <= '0;
			val_q    <= '0;
			prod_q   <= '0;
			sat_q    <= 1'b0;
			st_q     <= ST_OK;
			rid_q    <= '0;
			rcoeff_q <= '0;
			ovalid_q <= 1'b0;
			tdata_q  <= '0;
		end else begin
			if (cfg_wen) begin
				tol_q <= cfg_wdata;
			end
			// output register: loaded from the final state, freed by the receiver
			if (state_q == S_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						id_q     <= in_id;
						val_q    <= in_value;
						pos_q    <= '0;
						rcoeff_q <= '0;
						rid_q    <= (in_cmd == CMD_ADD_TERM) ? in_id : '0;
						st_q     <= (in_cmd == CMD_READ && !idx_ok) ? ST_RANGE : ST_OK;
						sat_q    <= (in_cmd == CMD_ADD_CONST) ? const_add.sat : 1'b0;
						case (in_cmd)
							CMD_ADD_TERM: begin
								state_q <= S_SCAN_RD;
							end
							CMD_SCALE: begin
								state_q <= S_SCL_RD;
							end
							CMD_ADD_CONST: begin
								const_q <= const_add.value;
								state_q <= S_DONE;
							end
							CMD_READ: begin
								state_q <= idx_ok ? S_READ_WAIT : S_DONE;
							end
							CMD_CLEAR: begin
								cnt_q   <= '0;
								const_q <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				// linear search for the first id not below the new one
				S_SCAN_RD: begin
					state_q <= (pos_q == cnt_q) ? S_NEW : S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (rd_q.id < id_q) begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else if (rd_q.id == id_q) begin
						sat_q <= add_r.sat;
						if (add_mag <= 32'(tol_q)) begin
							cur_q   <= pos_q;
							state_q <= S_ERASE_RD;
						end else begin
							rcoeff_q <= add_r.value;
							state_q  <= S_DONE;
						end
					end else begin
						state_q <= S_NEW;
					end
				end
				S_NEW: begin
					if (val_mag > 32'(tol_q)) begin
						if (cnt_q >= CNT_MAX) begin
							st_q    <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							cur_q    <= cnt_q;
							rcoeff_q <= val_q;
							state_q  <= S_INS_RD;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				// open a hole at pos by moving entries up, top first
				S_INS_RD: begin
					if (cur_q == pos_q) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					cur_q   <= cur_m1;
					state_q <= S_INS_RD;
				end
				// close the gap at pos by moving entries down
				S_ERASE_RD: begin
					if (cur_p1 >= cnt_q) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ERASE_WR;
					end
				end
				S_ERASE_WR: begin
					cur_q   <= cur_p1;
					state_q <= S_ERASE_RD;
				end
				S_SCL_RD: begin
					state_q <= (pos_q == cnt_q) ? S_CONST_MUL : S_SCL_MUL;
				end
				S_SCL_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_SCL_WR;
				end
				S_SCL_WR: begin
					sat_q   <= sat_q | mul_r.sat;
					pos_q   <= pos_q + 1'b1;
					state_q <= S_SCL_RD;
				end
				S_CONST_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_CONST_WR;
				end
				S_CONST_WR: begin
					const_q <= mul_r.value;
					sat_q   <= sat_q | mul_r.sat;
					state_q <= S_DONE;
				end
				S_READ_WAIT: begin
					rid_q    <= rd_q.id;
					rcoeff_q <= rd_q.coeff;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						tdata_q  <= {{(OUT_DATA_W - 90){1'b0}}, sat_q, const_q, rcoeff_q,
							rid_ext[15:0], cnt_ext[6:0], st_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count beyond table depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + 1'b1 ||
			cnt_q == $past(cnt_q) - 1'b1 || cnt_q == '0)
		else $error("entry count jumped");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CW'(mem_wa) <= cnt_q)
		else $error("table write outside live region");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && st_q == ST_FULL) |-> cnt_q == CNT_MAX)
		else $error("full status with free entries");

endmodule
